// ===== design/axis_homing_limit_supervisor_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the axis homing and limit supervisor
// Clocked property wrappers with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef AXIS_HOMING_LIMIT_SUPERVISOR_MACROS_SVH
`define AXIS_HOMING_LIMIT_SUPERVISOR_MACROS_SVH

// same-cycle implication
`define AHLS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ahls assertion failed");

// next-cycle implication
`define AHLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ahls assertion failed");

`endif

// ===== design/ahls_pkg.sv =====
// ----------------------------------------------------------------------------
// ahls_pkg
// Shared codes, defaults and control structs of the homing supervisor.
// ----------------------------------------------------------------------------
package ahls_pkg;

  // default sizes
  localparam int POSITION_BITS_DEF = 24;
  localparam int HOMING_SWEEP_DEF  = 100000;
  localparam int TIMER_BITS_DEF    = 20;

  // register reset values
  localparam logic LIMITS_ENABLE_RESET = 1'b1;
  localparam int   TIMEOUT_RESET_MS    = 10 * 60 * 1000;

  // register indexes
  localparam logic REG_SOFT_LIMITS_EN = 1'b0;
  localparam logic REG_REHOME_TIMEOUT = 1'b1;

  // phase codes
  localparam logic [2:0] PH_INIT   = 3'd0;
  localparam logic [2:0] PH_HMIN   = 3'd1;
  localparam logic [2:0] PH_HMAX   = 3'd2;
  localparam logic [2:0] PH_READY  = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;
  localparam logic [2:0] PH_WAIT   = 3'd5;
  localparam logic [2:0] PH_REHOME = 3'd6;

  // command codes
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_GOTO  = 3'd1;
  localparam logic [2:0] CMD_HOME  = 3'd2;
  localparam logic [2:0] CMD_RESET = 3'd3;
  localparam logic [2:0] CMD_SMIN  = 3'd4;
  localparam logic [2:0] CMD_SMAX  = 3'd5;

  // sensed bits and command of one word
  typedef struct packed {
    logic [2:0] cmd;
    logic       min_hit;
    logic       max_hit;
    logic [1:0] dir;
    logic       stall;
    logic       tick;
  } sense_t;

  // status and pulses of one result word
  typedef struct packed {
    logic [2:0] phase;
    logic       driver_enabled;
    logic       stop_request;
    logic       zero_position;
    logic       command_rejected;
  } flags_t;

endpackage

// ===== design/ahls_in_stage.sv =====
// ----------------------------------------------------------------------------
// ahls_in_stage
// Input register: holds one accepted word until the control pass takes it.
// ----------------------------------------------------------------------------
module ahls_in_stage
  import ahls_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sense_t                          sense_i,
  input  logic signed [POSITION_BITS-1:0] value_i,
  input  logic signed [POSITION_BITS-1:0] mpos_i,
  input  logic                            adv_i,
  output logic                            valid_o,
  output sense_t                          sense_o,
  output logic signed [POSITION_BITS-1:0] value_o,
  output logic signed [POSITION_BITS-1:0] mpos_o
);

  logic   valid_q, valid_d;
  logic   accept;
  sense_t sense_q;
  logic signed [POSITION_BITS-1:0] value_q, mpos_q;

  // stall only while the held word cannot move on
  assign in_stall_o = valid_q & ~adv_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign valid_d    = accept | (valid_q & ~adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sense_q <= sense_i;
      value_q <= value_i;
      mpos_q  <= mpos_i;
    end
  end

  assign valid_o = valid_q;
  assign sense_o = sense_q;
  assign value_o = value_q;
  assign mpos_o  = mpos_q;

endmodule

// ===== design/ahls_ctrl.sv =====
// ----------------------------------------------------------------------------
// ahls_ctrl
// Phase machine, soft limit window and wait timer; one pass per word.
// ----------------------------------------------------------------------------
module ahls_ctrl
  import ahls_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int HOMING_SWEEP  = HOMING_SWEEP_DEF,
  parameter int TIMER_BITS    = TIMER_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic                            limits_en_i,
  input  logic [TIMER_BITS-1:0]           timeout_i,
  input  sense_t                          sense_i,
  input  logic signed [POSITION_BITS-1:0] value_i,
  input  logic signed [POSITION_BITS-1:0] mpos_i,
  output flags_t                          flags_o,
  output logic signed [POSITION_BITS-1:0] target_o,
  output logic signed [POSITION_BITS-1:0] smin_o,
  output logic signed [POSITION_BITS-1:0] smax_o,
  output logic signed [POSITION_BITS-1:0] travel_o
);

  localparam logic signed [POSITION_BITS-1:0] SweepPos = POSITION_BITS'(HOMING_SWEEP);
  localparam logic signed [POSITION_BITS-1:0] SweepNeg = -SweepPos;
  localparam logic signed [POSITION_BITS-1:0] PosZero  = '0;

  function automatic logic signed [POSITION_BITS-1:0] clamp(
    input logic signed [POSITION_BITS-1:0] pos,
    input logic signed [POSITION_BITS-1:0] lo,
    input logic signed [POSITION_BITS-1:0] hi
  );
    logic signed [POSITION_BITS-1:0] r;
    r = pos;
    if (pos < lo) begin
      r = lo;
    end else if (pos > hi) begin
      r = hi;
    end
    return r;
  endfunction

  logic [2:0]      phase_q, phase_d;
  logic            latch_q, latch_d;
  logic            en_q, en_d;
  logic [TIMER_BITS-1:0] tmr_q, tmr_d, tmr_inc;
  logic signed [POSITION_BITS-1:0] travel_q, travel_d;
  logic signed [POSITION_BITS-1:0] smin_q, smin_d;
  logic signed [POSITION_BITS-1:0] smax_q, smax_d;
  logic signed [POSITION_BITS-1:0] target_q, target_d;
  logic signed [POSITION_BITS-1:0] win_lo, win_hi, mpos_adj, half;
  logic            ready, stop, zero, rej;

  // window candidate for a soft limit write
  always_comb begin
    win_lo = (sense_i.cmd == CMD_SMIN) ? value_i : smin_q;
    win_hi = (sense_i.cmd == CMD_SMIN) ? smax_q : value_i;
    if (win_lo < PosZero) begin
      win_lo = PosZero;
    end
    if (win_hi > travel_q) begin
      win_hi = travel_q;
    end
  end

  // mid-travel, rounded toward zero
  assign mpos_adj = mpos_i + $signed({{(POSITION_BITS-1){1'b0}}, mpos_i[POSITION_BITS-1]});
  assign half     = mpos_adj >>> 1;

  // wait timer, saturating
  assign tmr_inc = tmr_q + TIMER_BITS'(sense_i.tick && (tmr_q != '1));

  always_comb begin
    phase_d  = phase_q;
    latch_d  = latch_q;
    en_d     = en_q;
    tmr_d    = tmr_q;
    travel_d = travel_q;
    smin_d   = smin_q;
    smax_d   = smax_q;
    target_d = target_q;
    stop     = 1'b0;
    zero     = 1'b0;
    rej      = 1'b0;
    ready    = (phase_q == PH_READY);

    // command handling
    case (sense_i.cmd)
      CMD_GOTO: begin
        if (ready) begin
          target_d = limits_en_i ? clamp(value_i, smin_q, smax_q) : value_i;
        end else begin
          rej = 1'b1;
        end
      end
      CMD_HOME: begin
        latch_d = 1'b0;
        phase_d = PH_REHOME;
      end
      CMD_SMIN, CMD_SMAX: begin
        if (!ready || (win_lo >= win_hi)) begin
          rej = 1'b1;
        end else begin
          smin_d = win_lo;
          smax_d = win_hi;
        end
      end
      default: ;
    endcase

    // stall latch while ready
    if ((phase_d == PH_READY) && sense_i.stall) begin
      latch_d = 1'b1;
    end

    // phase machine
    case (phase_d)
      PH_HMIN: begin
        if (sense_i.min_hit) begin
          stop     = 1'b1;
          zero     = 1'b1;
          target_d = SweepPos;
          phase_d  = PH_HMAX;
        end
      end
      PH_HMAX: begin
        if (sense_i.max_hit) begin
          stop     = 1'b1;
          travel_d = mpos_i;
          smin_d   = PosZero;
          smax_d   = mpos_i;
          target_d = limits_en_i ? clamp(half, PosZero, mpos_i) : half;
          phase_d  = PH_READY;
        end
      end
      PH_READY: begin
        if ((sense_i.min_hit && (sense_i.dir == 2'b01)) ||
            (sense_i.max_hit && sense_i.dir[1]) || latch_d) begin
          stop    = 1'b1;
          en_d    = 1'b0;
          phase_d = PH_ERROR;
        end
      end
      PH_ERROR: begin
        stop    = 1'b1;
        en_d    = 1'b0;
        tmr_d   = '0;
        phase_d = PH_WAIT;
      end
      PH_WAIT: begin
        tmr_d = tmr_inc;
        if ((sense_i.cmd == CMD_RESET) || (tmr_inc >= timeout_i)) begin
          latch_d = 1'b0;
          phase_d = PH_REHOME;
        end
      end
      PH_REHOME: begin
        en_d     = 1'b1;
        target_d = SweepNeg;
        phase_d  = PH_HMIN;
      end
      default: begin
        target_d = SweepNeg;
        phase_d  = PH_HMIN;
      end
    endcase
  end

  // state update once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_INIT;
      latch_q  <= 1'b0;
      en_q     <= 1'b1;
      tmr_q    <= '0;
      travel_q <= '0;
      smin_q   <= '0;
      smax_q   <= '0;
      target_q <= '0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      latch_q  <= latch_d;
      en_q     <= en_d;
      tmr_q    <= tmr_d;
      travel_q <= travel_d;
      smin_q   <= smin_d;
      smax_q   <= smax_d;
      target_q <= target_d;
    end
  end

  assign flags_o.phase            = phase_d;
  assign flags_o.driver_enabled   = en_d;
  assign flags_o.stop_request     = stop;
  assign flags_o.zero_position    = zero;
  assign flags_o.command_rejected = rej;
  assign target_o = target_d;
  assign smin_o   = smin_d;
  assign smax_o   = smax_d;
  assign travel_o = travel_d;

endmodule

// ===== design/ahls_out_stage.sv =====
// ----------------------------------------------------------------------------
// ahls_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module ahls_out_stage
  import ahls_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  input  flags_t                          flags_i,
  input  logic signed [POSITION_BITS-1:0] target_i,
  input  logic signed [POSITION_BITS-1:0] smin_i,
  input  logic signed [POSITION_BITS-1:0] smax_i,
  input  logic signed [POSITION_BITS-1:0] travel_i,
  output flags_t                          flags_o,
  output logic signed [POSITION_BITS-1:0] target_o,
  output logic signed [POSITION_BITS-1:0] smin_o,
  output logic signed [POSITION_BITS-1:0] smax_o,
  output logic signed [POSITION_BITS-1:0] travel_o
);

  logic   valid_q, valid_d;
  flags_t flags_q;
  logic signed [POSITION_BITS-1:0] target_q, smin_q, smax_q, travel_q;

  // full after a load, empty once taken
  assign valid_d = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      flags_q  <= flags_i;
      target_q <= target_i;
      smin_q   <= smin_i;
      smax_q   <= smax_i;
      travel_q <= travel_i;
    end
  end

  assign out_valid_o = valid_q;
  assign flags_o     = flags_q;
  assign target_o    = target_q;
  assign smin_o      = smin_q;
  assign smax_o      = smax_q;
  assign travel_o    = travel_q;

endmodule

// ===== design/axis_homing_limit_supervisor.sv =====
// ----------------------------------------------------------------------------
// axis_homing_limit_supervisor
// Homing, soft limit and fault supervisor for one stepper axis.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one word per control pass with
//   command, value, end switches, position, direction, stall bit, ms tick.
//   Output channel (out_valid_o / out_stall_i): one result word per input
//   word: phase, driver enable, move target, stop/zero/reject pulses, soft
//   window and travel length.
//   One word per cycle is sustained while the receiver does not stall; the
//   whole control pass is combinational logic between the input register
//   and the result register. When the receiver stalls, the result register
//   holds its word and the input register holds one more; in_stall_o rises
//   only when both are full. Reset puts the axis in the init phase with the
//   driver enabled, all positions zero, limits enabled and a 600000 ms
//   re-home timeout. The user must make configuration writes (cfg_we_i)
//   only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "axis_homing_limit_supervisor_macros.svh"

module axis_homing_limit_supervisor
  import ahls_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int HOMING_SWEEP  = HOMING_SWEEP_DEF,
  parameter int TIMER_BITS    = TIMER_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [TIMER_BITS-1:0]           cfg_data_i,
  // input words
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      command_i,
  input  logic signed [POSITION_BITS-1:0] command_value_i,
  input  logic                            min_switch_hit_i,
  input  logic                            max_switch_hit_i,
  input  logic signed [POSITION_BITS-1:0] motor_position_i,
  input  logic signed [1:0]               motion_direction_i,
  input  logic                            stall_bit_i,
  input  logic                            ms_tick_i,
  // result words
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      phase_o,
  output logic                            driver_enabled_o,
  output logic signed [POSITION_BITS-1:0] move_target_o,
  output logic                            stop_request_o,
  output logic                            zero_position_o,
  output logic                            command_rejected_o,
  output logic signed [POSITION_BITS-1:0] soft_min_out_o,
  output logic signed [POSITION_BITS-1:0] soft_max_out_o,
  output logic signed [POSITION_BITS-1:0] travel_length_o
);

  logic                  limits_en_q;
  logic [TIMER_BITS-1:0] timeout_q;
  sense_t                sense_in, sense_q;
  logic                  s1_valid, adv;
  logic signed [POSITION_BITS-1:0] value_q, mpos_q;
  flags_t                flags_d, flags_q;
  logic signed [POSITION_BITS-1:0] target_d, smin_d, smax_d, travel_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_en_q <= LIMITS_ENABLE_RESET;
      timeout_q   <= TIMER_BITS'(TIMEOUT_RESET_MS);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SOFT_LIMITS_EN: limits_en_q <= cfg_data_i[0];
        REG_REHOME_TIMEOUT: timeout_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sense_in.cmd     = command_i;
  assign sense_in.min_hit = min_switch_hit_i;
  assign sense_in.max_hit = max_switch_hit_i;
  assign sense_in.dir     = motion_direction_i;
  assign sense_in.stall   = stall_bit_i;
  assign sense_in.tick    = ms_tick_i;

  // the held word moves on when the result register is free or being taken
  assign adv = s1_valid & (~out_valid_o | ~out_stall_i);

  ahls_in_stage #(
    .POSITION_BITS(POSITION_BITS)
  ) u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sense_i   (sense_in),
    .value_i   (command_value_i),
    .mpos_i    (motor_position_i),
    .adv_i     (adv),
    .valid_o   (s1_valid),
    .sense_o   (sense_q),
    .value_o   (value_q),
    .mpos_o    (mpos_q)
  );

  ahls_ctrl #(
    .POSITION_BITS(POSITION_BITS),
    .HOMING_SWEEP (HOMING_SWEEP),
    .TIMER_BITS   (TIMER_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .limits_en_i(limits_en_q),
    .timeout_i  (timeout_q),
    .sense_i    (sense_q),
    .value_i    (value_q),
    .mpos_i     (mpos_q),
    .flags_o    (flags_d),
    .target_o   (target_d),
    .smin_o     (smin_d),
    .smax_o     (smax_d),
    .travel_o   (travel_d)
  );

  ahls_out_stage #(
    .POSITION_BITS(POSITION_BITS)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (adv),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .flags_i    (flags_d),
    .target_i   (target_d),
    .smin_i     (smin_d),
    .smax_i     (smax_d),
    .travel_i   (travel_d),
    .flags_o    (flags_q),
    .target_o   (move_target_o),
    .smin_o     (soft_min_out_o),
    .smax_o     (soft_max_out_o),
    .travel_o   (travel_length_o)
  );

  assign phase_o            = flags_q.phase;
  assign driver_enabled_o   = flags_q.driver_enabled;
  assign stop_request_o     = flags_q.stop_request;
  assign zero_position_o    = flags_q.zero_position;
  assign command_rejected_o = flags_q.command_rejected;

  // checks
  `AHLS_ASSERT_IMPL(a_stall_only_full, clk_i, rst_ni, in_stall_o, s1_valid && out_valid_o)
  `AHLS_ASSERT_IMPL(a_fault_driver_off, clk_i, rst_ni,
    out_valid_o && ((phase_o == PH_ERROR) || (phase_o == PH_WAIT)), !driver_enabled_o)
  `AHLS_ASSERT_IMPL(a_zero_at_min, clk_i, rst_ni, out_valid_o && zero_position_o,
    (phase_o == PH_HMAX) && stop_request_o)
  `AHLS_ASSERT_IMPL(a_soft_min_nonneg, clk_i, rst_ni, out_valid_o,
    !soft_min_out_o[POSITION_BITS-1])

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: axis homing and limit supervisor
// Drives control-pass words through a homing, soft limit and fault sequence,
// predicts every result word in a behavioral model of the supervisor and
// compares each output word field by field, under random stalls on both
// channels and one long hold-off by the receiver.
// ----------------------------------------------------------------------------
module testbench;
  import ahls_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 5;
  localparam int SETTLE_WAIT  = 6;
  localparam int IDLE_LIMIT   = 3000;  // cycles with no word moved on either channel
  localparam int HOLD_CYCLES  = 60;
  localparam int HOLD_AT      = 300;
  localparam int PHASE_WORDS  = 130;
  localparam int NUM_SETTINGS = 5;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam logic [1:0] DIR_STILL   = 2'b00;
  localparam logic [1:0] DIR_FWD     = 2'b01;
  localparam logic [1:0] DIR_REV_ALT = 2'b10;
  localparam logic [1:0] DIR_REV     = 2'b11;

  localparam logic signed [23:0] SWEEP     = 24'(HOMING_SWEEP_DEF);
  localparam logic [19:0]        TIMER_TOP = '1;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [23:0] val;
    logic               min_hit;
    logic               max_hit;
    logic signed [23:0] mpos;
    logic [1:0]         dir;
    logic               stall;
    logic               tick;
  } in_word_t;

  typedef struct {
    logic [2:0]         phase;
    logic               enabled;
    logic signed [23:0] target;
    logic               stop;
    logic               zero;
    logic               rejected;
    logic signed [23:0] smin;
    logic signed [23:0] smax;
    logic signed [23:0] travel;
  } res_word_t;

  // DUT ports
  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [19:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         command_i;
  logic signed [23:0] command_value_i;
  logic               min_switch_hit_i;
  logic               max_switch_hit_i;
  logic signed [23:0] motor_position_i;
  logic signed [1:0]  motion_direction_i;
  logic               stall_bit_i;
  logic               ms_tick_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [2:0]         phase_o;
  logic               driver_enabled_o;
  logic signed [23:0] move_target_o;
  logic               stop_request_o;
  logic               zero_position_o;
  logic               command_rejected_o;
  logic signed [23:0] soft_min_out_o;
  logic signed [23:0] soft_max_out_o;
  logic signed [23:0] travel_length_o;

  axis_homing_limit_supervisor dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .command_value_i    (command_value_i),
    .min_switch_hit_i   (min_switch_hit_i),
    .max_switch_hit_i   (max_switch_hit_i),
    .motor_position_i   (motor_position_i),
    .motion_direction_i (motion_direction_i),
    .stall_bit_i        (stall_bit_i),
    .ms_tick_i          (ms_tick_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .phase_o            (phase_o),
    .driver_enabled_o   (driver_enabled_o),
    .move_target_o      (move_target_o),
    .stop_request_o     (stop_request_o),
    .zero_position_o    (zero_position_o),
    .command_rejected_o (command_rejected_o),
    .soft_min_out_o     (soft_min_out_o),
    .soft_max_out_o     (soft_max_out_o),
    .travel_length_o    (travel_length_o)
  );

  // supervisor model state, starts at its reset value
  logic [2:0]         sv_phase  = PH_INIT;
  logic               sv_stall  = 1'b0;
  logic signed [23:0] sv_travel = '0;
  logic signed [23:0] sv_smin   = '0;
  logic signed [23:0] sv_smax   = '0;
  logic signed [23:0] sv_target = '0;
  logic [19:0]        sv_timer  = '0;
  logic               sv_enable = 1'b1;
  logic               lim_enable = LIMITS_ENABLE_RESET;
  logic [19:0]        rehome_ms  = 20'(TIMEOUT_RESET_MS);

  res_word_t pending_results[$];
  in_word_t  table_in[$];
  res_word_t table_exp[$];
  bit        table_typed[$];

  bit calm;
  int fail_count;
  int words_sent;
  int results_seen;
  int homings_done;
  int faults_seen;
  int refused_seen;
  int idle_cycles;

  // clock
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // supervisor model
  // ---------------------------------------------------------------------------

  // move target, clamped to the soft window when limits are on
  function automatic logic signed [23:0] clamp_target(input logic signed [23:0] pos);
    if (lim_enable) begin
      if (pos < sv_smin) return sv_smin;
      if (pos > sv_smax) return sv_smax;
    end
    return pos;
  endfunction

  // soft window write; refused when the trimmed window is empty
  function automatic bit try_window(input logic signed [23:0] lo,
                                    input logic signed [23:0] hi);
    if (lo < 0) lo = '0;
    if (hi > sv_travel) hi = sv_travel;
    if (lo >= hi) return 1'b0;
    sv_smin = lo;
    sv_smax = hi;
    return 1'b1;
  endfunction

  // one control pass: command first, then stall latch, then phase machine
  function automatic res_word_t supervise_pass(input in_word_t w);
    res_word_t r;
    bit ready;
    r = '{default: '0};
    ready = (sv_phase == PH_READY);

    case (w.cmd)
      CMD_GOTO: begin
        if (ready) sv_target = clamp_target(w.val);
        else r.rejected = 1'b1;
      end
      CMD_HOME: begin
        sv_stall = 1'b0;
        sv_phase = PH_REHOME;
      end
      CMD_SMIN: begin
        if (!ready) r.rejected = 1'b1;
        else if (!try_window(w.val, sv_smax)) r.rejected = 1'b1;
      end
      CMD_SMAX: begin
        if (!ready) r.rejected = 1'b1;
        else if (!try_window(sv_smin, w.val)) r.rejected = 1'b1;
      end
      default: ;
    endcase

    if (sv_phase == PH_READY && w.stall) sv_stall = 1'b1;

    case (sv_phase)
      PH_HMIN: begin
        if (w.min_hit) begin
          r.stop    = 1'b1;
          r.zero    = 1'b1;
          sv_target = SWEEP;
          sv_phase  = PH_HMAX;
        end
      end
      PH_HMAX: begin
        if (w.max_hit) begin
          r.stop    = 1'b1;
          sv_travel = w.mpos;
          sv_smin   = '0;
          sv_smax   = w.mpos;
          sv_target = clamp_target(w.mpos / 24'sd2);
          sv_phase  = PH_READY;
          homings_done++;
        end
      end
      PH_READY: begin
        // switch hit while moving into it, or a latched stall
        if ((w.min_hit && w.dir == DIR_FWD) || (w.max_hit && w.dir[1]) || sv_stall) begin
          r.stop    = 1'b1;
          sv_enable = 1'b0;
          sv_phase  = PH_ERROR;
          faults_seen++;
        end
      end
      PH_ERROR: begin
        r.stop    = 1'b1;
        sv_enable = 1'b0;
        sv_timer  = '0;
        sv_phase  = PH_WAIT;
      end
      PH_WAIT: begin
        if (w.tick && sv_timer != TIMER_TOP) sv_timer = sv_timer + 20'd1;
        if (w.cmd == CMD_RESET || sv_timer >= rehome_ms) begin
          sv_stall = 1'b0;
          sv_phase = PH_REHOME;
        end
      end
      PH_REHOME: begin
        sv_enable = 1'b1;
        sv_target = -SWEEP;
        sv_phase  = PH_HMIN;
      end
      default: begin
        sv_target = -SWEEP;
        sv_phase  = PH_HMIN;
      end
    endcase

    if (r.rejected) refused_seen++;
    r.phase   = sv_phase;
    r.enabled = sv_enable;
    r.target  = sv_target;
    r.smin    = sv_smin;
    r.smax    = sv_smax;
    r.travel  = sv_travel;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_word_t pass_in(input logic [2:0] c, input int v, input logic mn,
                                       input logic mx, input int p, input logic [1:0] d,
                                       input logic s, input logic t);
    in_word_t w;
    w.cmd = c;  w.val = 24'(v);  w.min_hit = mn;  w.max_hit = mx;
    w.mpos = 24'(p);  w.dir = d;  w.stall = s;  w.tick = t;
    return w;
  endfunction

  function automatic res_word_t pass_out(input logic [2:0] ph, input logic en, input int tgt,
                                         input logic stp, input logic zr, input logic rj,
                                         input int lo, input int hi, input int trv);
    res_word_t r;
    r.phase = ph;  r.enabled = en;  r.target = 24'(tgt);  r.stop = stp;  r.zero = zr;
    r.rejected = rj;  r.smin = 24'(lo);  r.smax = 24'(hi);  r.travel = 24'(trv);
    return r;
  endfunction

  task automatic row(input in_word_t w);
    table_in.push_back(w);
    table_exp.push_back('{default: '0});
    table_typed.push_back(1'b0);
  endtask

  task automatic row_exp(input in_word_t w, input res_word_t e);
    table_in.push_back(w);
    table_exp.push_back(e);
    table_typed.push_back(1'b1);
  endtask

  // position recorded at the max switch: mostly modest, sometimes odd
  function automatic logic signed [23:0] pick_travel();
    case ($urandom_range(19))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2:       return 24'($urandom);
      3:       return 24'(-int'($urandom_range(1, 5000)));
      4:       return 24'($urandom_range(0, 2));
      default: return 24'($urandom_range(200, 60000));
    endcase
  endfunction

  // value around the travel range so soft writes and clamps both get hit
  function automatic logic signed [23:0] near_window();
    int t;
    int base;
    t = sv_travel;
    if ($urandom_range(9) == 0) return 24'($urandom);
    base = (t < 0 ? t : 0) - 100;
    return 24'(base + int'($urandom_range((t < 0 ? -t : t) + 200)));
  endfunction

  // next word, shaped by where the axis is in its sequence
  function automatic in_word_t pick_word();
    in_word_t w;
    int pick;
    w.cmd = CMD_NONE;  w.val = 24'($urandom);  w.min_hit = 1'b0;  w.max_hit = 1'b0;
    w.mpos = 24'($urandom);  w.dir = 2'($urandom);  w.stall = 1'b0;  w.tick = 1'($urandom);

    // noise: any code, any switch pattern
    if ($urandom_range(99) < 8) begin
      w.cmd     = 3'($urandom);
      w.min_hit = 1'($urandom);
      w.max_hit = 1'($urandom);
      w.stall   = 1'($urandom);
      return w;
    end

    case (sv_phase)
      PH_HMIN: w.min_hit = ($urandom_range(99) < 30);
      PH_HMAX: begin
        w.max_hit = ($urandom_range(99) < 30);
        w.mpos    = pick_travel();
      end
      PH_READY: begin
        pick = $urandom_range(99);
        if (pick < 30) w.cmd = CMD_GOTO;
        else if (pick < 42) w.cmd = CMD_SMIN;
        else if (pick < 54) w.cmd = CMD_SMAX;
        else if (pick < 57) w.cmd = CMD_RESET;
        w.val     = near_window();
        w.min_hit = ($urandom_range(99) < 4);
        w.max_hit = ($urandom_range(99) < 4);
        w.stall   = ($urandom_range(99) < 1);
      end
      PH_WAIT: begin
        w.tick = ($urandom_range(99) < 80);
        if ($urandom_range(99) < 5) w.cmd = CMD_RESET;
      end
      default: ;
    endcase

    if ($urandom_range(99) < 2) w.cmd = CMD_HOME;
    return w;
  endfunction

  // offer one word, with a random gap first, and wait for it to be taken
  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 26) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    command_i          <= w.cmd;
    command_value_i    <= w.val;
    min_switch_hit_i   <= w.min_hit;
    max_switch_hit_i   <= w.max_hit;
    motor_position_i   <= w.mpos;
    motion_direction_i <= w.dir;
    stall_bit_i        <= w.stall;
    ms_tick_i          <= w.tick;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // stop offering and let every pending result drain
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  // program both registers while idle
  task automatic load_settings(input logic lim, input logic [19:0] tmo);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SOFT_LIMITS_EN;
    cfg_data_i <= {19'd0, lim};
    @(posedge clk_i);
    cfg_idx_i  <= REG_REHOME_TIMEOUT;
    cfg_data_i <= tmo;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    lim_enable = lim;
    rehome_ms  = tmo;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    res_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t result word with no expectation pending", $time);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("phase", e.phase, phase_o);
        check_field("driver_enabled", e.enabled, driver_enabled_o);
        check_field("move_target", e.target, move_target_o);
        check_field("stop_request", e.stop, stop_request_o);
        check_field("zero_position", e.zero, zero_position_o);
        check_field("command_rejected", e.rejected, command_rejected_o);
        check_field("soft_min_out", e.smin, soft_min_out_o);
        check_field("soft_max_out", e.smax, soft_max_out_o);
        check_field("travel_length", e.travel, travel_length_o);
        results_seen++;
      end
    end
  end

  // watchdog on cycles where neither channel moves a word
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, a calm stretch
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= !calm && ($urandom_range(99) < 26);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic        lim_list[NUM_SETTINGS];
    logic [19:0] tmo_list[NUM_SETTINGS];
    in_word_t    w;
    res_word_t   r;

    lim_list = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    tmo_list = '{20'd4, 20'd0, 20'hFFFFF, 20'd30, 20'd1};

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_SOFT_LIMITS_EN;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    command_i          = CMD_NONE;
    command_value_i    = '0;
    min_switch_hit_i   = 1'b0;
    max_switch_hit_i   = 1'b0;
    motor_position_i   = '0;
    motion_direction_i = DIR_STILL;
    stall_bit_i        = 1'b0;
    ms_tick_i          = 1'b0;
    calm               = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full homing at the largest travel, window edits, a fault,
    // recovery by RESET and HOME during homing
    row_exp(pass_in(CMD_NONE, 0, 0, 0, 0, DIR_STILL, 0, 0),
            pass_out(PH_HMIN, 1, -HOMING_SWEEP_DEF, 0, 0, 0, 0, 0, 0));
    row_exp(pass_in(CMD_GOTO, 8388607, 0, 0, 0, DIR_REV, 0, 1),
            pass_out(PH_HMIN, 1, -HOMING_SWEEP_DEF, 0, 0, 1, 0, 0, 0));
    row_exp(pass_in(CMD_SMIN, -8388608, 0, 1, -8388608, DIR_FWD, 1, 0),
            pass_out(PH_HMIN, 1, -HOMING_SWEEP_DEF, 0, 0, 1, 0, 0, 0));
    row_exp(pass_in(CMD_NONE, 0, 1, 0, 0, DIR_REV, 0, 0),
            pass_out(PH_HMAX, 1, HOMING_SWEEP_DEF, 1, 1, 0, 0, 0, 0));
    row_exp(pass_in(CMD_NONE, 0, 0, 1, 8388607, DIR_FWD, 0, 0),
            pass_out(PH_READY, 1, 4194303, 1, 0, 0, 0, 8388607, 8388607));
    row(pass_in(CMD_GOTO, -8388608, 0, 0, 0, DIR_STILL, 0, 0));
    row(pass_in(CMD_GOTO, 8388607, 0, 0, 0, DIR_FWD, 0, 1));
    row(pass_in(CMD_SMIN, -8388608, 0, 0, 0, DIR_STILL, 0, 0));
    row(pass_in(CMD_SMIN, 1000, 0, 0, 0, DIR_STILL, 0, 0));
    row(pass_in(CMD_SMAX, 500, 0, 0, 0, DIR_STILL, 0, 0));
    row(pass_in(CMD_SMAX, 200000, 0, 0, 0, DIR_STILL, 0, 0));
    row(pass_in(CMD_SMIN, 200000, 0, 0, 0, DIR_STILL, 0, 0));
    row(pass_in(CMD_GOTO, 0, 0, 0, 0, DIR_STILL, 0, 0));
    row(pass_in(CMD_SPARE6, 5, 0, 0, 0, DIR_STILL, 0, 0));
    row(pass_in(CMD_SPARE7, -5, 0, 0, 0, DIR_STILL, 0, 0));
    row(pass_in(CMD_RESET, 0, 0, 0, 0, DIR_STILL, 0, 0));
    row(pass_in(CMD_NONE, 0, 1, 0, 0, DIR_REV, 0, 0));          // min switch, backing off
    row(pass_in(CMD_NONE, 0, 0, 1, 0, DIR_FWD, 0, 0));          // max switch, backing off
    row(pass_in(CMD_NONE, 0, 0, 1, 0, DIR_REV_ALT, 0, 0));      // into max switch: fault
    row(pass_in(CMD_NONE, 0, 0, 0, 0, DIR_STILL, 0, 1));
    row(pass_in(CMD_NONE, 0, 0, 0, 0, DIR_STILL, 0, 1));
    row(pass_in(CMD_RESET, 0, 0, 0, 0, DIR_STILL, 0, 0));
    row(pass_in(CMD_NONE, 0, 0, 0, 0, DIR_STILL, 0, 0));
    row(pass_in(CMD_NONE, 0, 1, 0, 0, DIR_REV, 0, 0));
    row(pass_in(CMD_HOME, 0, 0, 0, 0, DIR_STILL, 0, 0));        // home during homing

    foreach (table_in[i]) begin
      r = supervise_pass(table_in[i]);
      pending_results.push_back(table_typed[i] ? table_exp[i] : r);
      send_word(table_in[i]);
    end

    // random phases, each under its own limit and timeout setting
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      drain();
      load_settings(lim_list[s], tmo_list[s]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        calm = (s == 1) && (n >= 20) && (n < 100);
        w = pick_word();
        pending_results.push_back(supervise_pass(w));
        send_word(w);
      end
      calm = 1'b0;
    end

    drain();
    $display("Covered %0d words over %0d limit/timeout settings: %0d homings, %0d faults,",
             words_sent, NUM_SETTINGS + 1, homings_done, faults_seen);
    $display("%0d refused commands, %0d result words compared, %0d mismatches.",
             refused_seen, results_seen, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
